// File: hdl/hsg_pkg.sv
// Shared types, constants and the exp table builder for the heat stencil block.
package hsg_pkg;

	localparam int TEMP_W     = 24;
	localparam int GAIN_W     = 32;
	localparam int OFS_W      = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam int EXP_DEPTH  = 1024;
	localparam int EXP_AW     = $clog2(EXP_DEPTH);
	localparam int EXP_W      = 17;

	// squares of Q6.12 offsets are Q12.24; their sum fits in 38 bits
	localparam int SQ_W       = 2 * OFS_W - 1;
	localparam int F_W        = SQ_W + 1;
	localparam int F_SHIFT    = 28;
	localparam int SCALED_W   = F_W + $clog2(EXP_DEPTH + 1);

	localparam int LAP_W      = TEMP_W + 4;
	localparam int PROD_W     = LAP_W + GAIN_W;
	localparam int DIFF_W     = PROD_W + 1 - 32;
	localparam int G_W        = GAIN_W + EXP_W;
	localparam int SRC_W      = G_W + 1 - 24;
	localparam int RES_W      = 31;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOLIDUS      = 3'd0,
		REG_LIQUIDUS     = 3'd1,
		REG_DGAIN_PLAIN  = 3'd2,
		REG_DGAIN_MUSHY  = 3'd3,
		REG_SGAIN_PLAIN  = 3'd4,
		REG_SGAIN_MUSHY  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [TEMP_W-1:0] solidus;
		logic [TEMP_W-1:0] liquidus;
		logic [GAIN_W-1:0] dgain_plain;
		logic [GAIN_W-1:0] dgain_mushy;
		logic [GAIN_W-1:0] sgain_plain;
		logic [GAIN_W-1:0] sgain_mushy;
	} cfg_t;

	typedef logic [EXP_W-1:0] exp_tab_t [EXP_DEPTH];

	// entry i ~ 2^16 * exp(-16 i / EXP_DEPTH), built in Q1.31 by repeated products
	function automatic exp_tab_t exp_table();
		exp_tab_t   t;
		logic [63:0] s;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] q;
		logic [63:0] e;
		s    = (64'd16 << 31) / 64'(EXP_DEPTH);
		term = 64'd1 << 31;
		pos  = term;
		neg  = 64'd0;
		for (int k = 1; k <= 12; k++) begin
			term = ((term * s) >> 31) / 64'(k);
			if (k % 2 == 1) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		q = pos - neg;
		e = 64'd1 << 31;
		for (int i = 0; i < EXP_DEPTH; i++) begin
			t[i] = EXP_W'((e + (64'd1 << 14)) >> 15);
			e    = (e * q + (64'd1 << 30)) >> 31;
		end
		return t;
	endfunction

endpackage

// File: hdl/hsg_cfg.sv
// Configuration register file: zone bounds and gains.
module hsg_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [hsg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [hsg_pkg::CFG_DATA_W-1:0]  cfg_data,
	output hsg_pkg::cfg_t                   cfg
);

	hsg_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (hsg_pkg::cfg_idx_t'(cfg_index))
				hsg_pkg::REG_SOLIDUS:     cfg_q.solidus     <= cfg_data[hsg_pkg::TEMP_W-1:0];
				hsg_pkg::REG_LIQUIDUS:    cfg_q.liquidus    <= cfg_data[hsg_pkg::TEMP_W-1:0];
				hsg_pkg::REG_DGAIN_PLAIN: cfg_q.dgain_plain <= cfg_data[hsg_pkg::GAIN_W-1:0];
				hsg_pkg::REG_DGAIN_MUSHY: cfg_q.dgain_mushy <= cfg_data[hsg_pkg::GAIN_W-1:0];
				hsg_pkg::REG_SGAIN_PLAIN: cfg_q.sgain_plain <= cfg_data[hsg_pkg::GAIN_W-1:0];
				hsg_pkg::REG_SGAIN_MUSHY: cfg_q.sgain_mushy <= cfg_data[hsg_pkg::GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hdl/hsg_exp_rom.sv
// Constant exp(-f) table with a registered read port.
module hsg_exp_rom (
	input  logic                         clk,
	input  logic [hsg_pkg::EXP_AW-1:0]   addr,
	output logic [hsg_pkg::EXP_W-1:0]    data
);

	localparam hsg_pkg::exp_tab_t EXP_TAB = hsg_pkg::exp_table();

	logic [hsg_pkg::EXP_W-1:0] data_q;

	always_ff @(posedge clk) begin
		data_q <= EXP_TAB[addr];
	end

	assign data = data_q;

endmodule

// File: hdl/hsg_pipe.sv
// Four-stage update datapath: Laplacian, gain products, exp lookup, sum and saturation.
module hsg_pipe (
	input  logic                          clk,
	input  logic                          arst_n,
	input  hsg_pkg::cfg_t                 cfg,
	input  logic                          in_vld,
	input  logic [hsg_pkg::TEMP_W-1:0]    center_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]    west_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]    east_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]    south_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]    north_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]    below_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]    above_temp,
	input  logic signed [hsg_pkg::OFS_W-1:0] offset_x,
	input  logic signed [hsg_pkg::OFS_W-1:0] offset_y,
	input  logic signed [hsg_pkg::OFS_W-1:0] offset_z,
	output logic                          out_vld,
	output logic [hsg_pkg::TEMP_W-1:0]    new_temp,
	output logic                          clipped
);

	localparam int TW = hsg_pkg::TEMP_W;
	localparam int NW = TW + 3;
	localparam logic [hsg_pkg::RES_W-1:0] TEMP_MAX = hsg_pkg::RES_W'({TW{1'b1}});

	// stage 1
	logic [NW-1:0]                        nsum;
	logic [NW-1:0]                        six_c;
	logic                                 mushy;
	logic signed [2*hsg_pkg::OFS_W-1:0]   sqx, sqy, sqz;

	logic                                 vld_s1;
	logic [TW-1:0]                        c_s1;
	logic signed [hsg_pkg::LAP_W-1:0]     lap_s1;
	logic [hsg_pkg::GAIN_W-1:0]           dgain_s1;
	logic [hsg_pkg::GAIN_W-1:0]           sgain_s1;
	logic                                 beam_s1;
	logic [hsg_pkg::SQ_W-1:0]             sqx_s1, sqy_s1, sqz_s1;

	// stage 2
	logic [hsg_pkg::F_W-1:0]              f_sum;
	logic [hsg_pkg::SCALED_W-1:0]         scaled;
	logic                                 in_tab;
	logic [hsg_pkg::EXP_AW-1:0]           rom_addr;
	logic [hsg_pkg::EXP_W-1:0]            entry_s2;
	logic signed [hsg_pkg::PROD_W-1:0]    prod;

	logic                                 vld_s2;
	logic [TW-1:0]                        c_s2;
	logic signed [hsg_pkg::PROD_W-1:0]    prod_s2;
	logic [hsg_pkg::GAIN_W-1:0]           sgain_s2;
	logic                                 src_en_s2;

	// stage 3
	logic signed [hsg_pkg::PROD_W:0]      prod_r;

	logic                                 vld_s3;
	logic [TW-1:0]                        c_s3;
	logic signed [hsg_pkg::DIFF_W-1:0]    diff_s3;
	logic [hsg_pkg::G_W-1:0]              g_s3;

	// stage 4
	logic [hsg_pkg::G_W:0]                g_r;
	logic [hsg_pkg::SRC_W-1:0]            src;
	logic signed [hsg_pkg::RES_W-1:0]     res;

	logic                                 vld_s4;
	logic [TW-1:0]                        new_temp_s4;
	logic                                 clipped_s4;

	always_comb begin
		nsum  = NW'(west_temp) + NW'(east_temp) + NW'(south_temp)
			+ NW'(north_temp) + NW'(below_temp) + NW'(above_temp);
		six_c = NW'({center_temp, 2'b00}) + NW'({center_temp, 1'b0});
		mushy = (center_temp >= cfg.solidus) && (center_temp <= cfg.liquidus);
		sqx   = offset_x * offset_x;
		sqy   = offset_y * offset_y;
		sqz   = offset_z * offset_z;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		c_s1     <= center_temp;
		lap_s1   <= $signed({1'b0, nsum}) - $signed({1'b0, six_c});
		dgain_s1 <= mushy ? cfg.dgain_mushy : cfg.dgain_plain;
		sgain_s1 <= mushy ? cfg.sgain_mushy : cfg.sgain_plain;
		beam_s1  <= (cfg.sgain_plain != '0);
		sqx_s1   <= sqx[hsg_pkg::SQ_W-1:0];
		sqy_s1   <= sqy[hsg_pkg::SQ_W-1:0];
		sqz_s1   <= sqz[hsg_pkg::SQ_W-1:0];
	end

	always_comb begin
		f_sum    = hsg_pkg::F_W'(sqx_s1) + hsg_pkg::F_W'(sqy_s1) + hsg_pkg::F_W'(sqz_s1);
		scaled   = hsg_pkg::SCALED_W'(f_sum) * hsg_pkg::SCALED_W'(hsg_pkg::EXP_DEPTH);
		in_tab   = (scaled >> hsg_pkg::F_SHIFT) < hsg_pkg::SCALED_W'(hsg_pkg::EXP_DEPTH);
		rom_addr = scaled[hsg_pkg::F_SHIFT +: hsg_pkg::EXP_AW];
		prod     = lap_s1 * $signed({1'b0, dgain_s1});
	end

	hsg_exp_rom u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (entry_s2)
	);

	always_ff @(posedge clk) begin
		c_s2      <= c_s1;
		prod_s2   <= prod;
		sgain_s2  <= sgain_s1;
		src_en_s2 <= beam_s1 && in_tab;
	end

	// round half up, floor shift
	assign prod_r = {prod_s2[hsg_pkg::PROD_W-1], prod_s2}
		+ ((hsg_pkg::PROD_W+1)'(1) << 31);

	always_ff @(posedge clk) begin
		c_s3    <= c_s2;
		diff_s3 <= prod_r[hsg_pkg::PROD_W:32];
		g_s3    <= src_en_s2 ? hsg_pkg::G_W'(sgain_s2) * hsg_pkg::G_W'(entry_s2) : '0;
	end

	always_comb begin
		g_r = {1'b0, g_s3} + ((hsg_pkg::G_W+1)'(1) << 23);
		src = g_r[hsg_pkg::G_W:24];
		res = $signed(hsg_pkg::RES_W'(c_s3))
			+ hsg_pkg::RES_W'(diff_s3)
			+ $signed(hsg_pkg::RES_W'(src));
	end

	always_ff @(posedge clk) begin
		if (res[hsg_pkg::RES_W-1]) begin
			new_temp_s4 <= '0;
			clipped_s4  <= 1'b1;
		end else if (res > $signed(TEMP_MAX)) begin
			new_temp_s4 <= {TW{1'b1}};
			clipped_s4  <= 1'b1;
		end else begin
			new_temp_s4 <= res[TW-1:0];
			clipped_s4  <= 1'b0;
		end
	end

	assign out_vld  = vld_s4;
	assign new_temp = new_temp_s4;
	assign clipped  = clipped_s4;

endmodule

// File: hdl/heat_stencil_gaussian_source.sv
// Top level: one explicit heat update per cell with a Gaussian beam source.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-------------------------------------------
//  cell in   | start, busy          | center/west/east/south/north/below/above_temp,
//            |                      | offset_x, offset_y, offset_z
//  result    | done (one cycle)     | new_temp, clipped
//  config    | cfg_we               | cfg_index, cfg_data
//
// One transaction per clock; each result shows done once it leaves the pipeline.
// Latency is set by the four pipeline stages: Laplacian and squares, gain product
// and exp table read, source product, then sum and saturation.
// busy stays low: the receiver cannot stall, so the pipeline never holds.
// Reset clears the config registers and pipeline valid bits; the exp table is constant.
module heat_stencil_gaussian_source (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic [hsg_pkg::TEMP_W-1:0]        center_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]        west_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]        east_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]        south_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]        north_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]        below_temp,
	input  logic [hsg_pkg::TEMP_W-1:0]        above_temp,
	input  logic signed [hsg_pkg::OFS_W-1:0]  offset_x,
	input  logic signed [hsg_pkg::OFS_W-1:0]  offset_y,
	input  logic signed [hsg_pkg::OFS_W-1:0]  offset_z,
	output logic                              done,
	output logic [hsg_pkg::TEMP_W-1:0]        new_temp,
	output logic                              clipped,
	input  logic                              cfg_we,
	input  logic [hsg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hsg_pkg::CFG_DATA_W-1:0]    cfg_data
);

	hsg_pkg::cfg_t cfg;

	assign busy = 1'b0;

	hsg_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	hsg_pipe u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_vld      (start && !busy),
		.center_temp (center_temp),
		.west_temp   (west_temp),
		.east_temp   (east_temp),
		.south_temp  (south_temp),
		.north_temp  (north_temp),
		.below_temp  (below_temp),
		.above_temp  (above_temp),
		.offset_x    (offset_x),
		.offset_y    (offset_y),
		.offset_z    (offset_z),
		.out_vld     (done),
		.new_temp    (new_temp),
		.clipped     (clipped)
	);

endmodule

// File: hdl/hsg_checker.sv
// Port-level checks for the heat stencil block, bound to the top level.
module hsg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [hsg_pkg::TEMP_W-1:0]  new_temp,
	input logic                        clipped
);

	// every accepted transaction yields a result after the fixed latency
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##4 done)
		else $error("accepted transaction produced no result");

	// no result without a matching accepted transaction earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##4 !done)
		else $error("result without a transaction");

	// a clipped result sits on a range bound
	a_clip_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clipped) |-> (new_temp == '0 || new_temp == {hsg_pkg::TEMP_W{1'b1}}))
		else $error("clipped result not at a range bound");

endmodule

bind heat_stencil_gaussian_source hsg_checker u_hsg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.new_temp (new_temp),
	.clipped  (clipped)
);
